/* rtl/lzw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_pkg
// Types, constants and helpers shared by the LZW hash encoder.
// ----------------------------------------------------------------------------
package lzw_pkg;

	localparam int HashEntries = 5003;
	localparam int MaxCodeBits = 12;
	localparam int HashShift   = 5;
	localparam int IdxW        = $clog2(HashEntries);

	localparam logic [0:0] OpSymbol = 1'b0;
	localparam logic [0:0] OpFinish = 1'b1;

	localparam logic [0:0] RegMinCodeSize = 1'b0;
	localparam logic [0:0] RegTiffMode    = 1'b1;

	typedef struct packed {
		logic [0:0] operation;
		logic [7:0] symbol;
	} lzw_in_t;

	typedef struct packed {
		logic [11:0] out_code;
		logic [3:0]  out_width;
		logic        last_of_run;
	} lzw_out_t;

	typedef struct packed {
		logic [11:0] code;
		logic [11:0] prefix;
		logic [7:0]  suffix;
	} lzw_entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_CHECK,
		ST_MISS
	} lzw_state_t;

	function automatic logic [3:0] root_from_reg(input logic [3:0] v);
		logic [3:0] r;
		r = v;
		if (v < 4'd2) r = 4'd2;
		if (v > 4'd8) r = 4'd8;
		return r;
	endfunction

	function automatic logic [12:0] limit_for(input logic [3:0] w, input logic tiff);
		return (13'd1 << w) - {12'd0, tiff};
	endfunction

endpackage

/* rtl/lzw_hash_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_hash_encoder
// Variable-width LZW encoder with a hashed string table and growing probe.
// ----------------------------------------------------------------------------
// Requests on in_data carry a symbol or a finish operation; each produces up
// to two codes on out_data, each with the width it is written at, the final
// one flagged last_of_run. Register writes on cfg_* are always taken and
// apply at the next stream start.
// A symbol request is hashed in the cycle it is taken, then each probe of the
// table memory (separate read and write ports) passes through a read state and
// a compare state, and a miss then passes through an insert state that also
// queues its code. A hit frees the input on its return to idle; a miss frees
// it only once its code is taken.
// in_ready is high only when the sequencer is idle and no code waits.
// After reset, after a finish of an open stream and after a table-full clear,
// the table is swept one entry per cycle over all 5003 entries before in_ready rises.
// Codes are held in a two-entry output queue; while the receiver stalls,
// in_ready stays low and no code is lost.
// ----------------------------------------------------------------------------
module lzw_hash_encoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [3:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  lzw_pkg::lzw_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output lzw_pkg::lzw_out_t  out_data
);
	import lzw_pkg::*;

	localparam logic [IdxW-1:0] LastIdx = IdxW'(HashEntries - 1);
	localparam logic [IdxW:0]   NWide   = (IdxW + 1)'(HashEntries);

	lzw_state_t state_q, state_d;

	lzw_entry_t mem [HashEntries];
	lzw_entry_t rd_q;
	logic              wr_en;
	logic [IdxW-1:0]   wr_addr;
	lzw_entry_t        wr_data;

	logic [3:0]  reg_min_q;
	logic        reg_tiff_q;
	logic [3:0]  root_q;
	logic        tiff_q;
	logic [11:0] pending_q;
	logic        have_q;
	logic [12:0] next_free_q;
	logic [3:0]  width_q;
	logic [12:0] limit_q;
	logic [7:0]  sym_q;
	logic [IdxW-1:0] hx_q, step_q, clr_q;
	logic [IdxW-1:0] tries_q;
	logic        empty_q;

	lzw_out_t    q0_q, q1_q;
	logic [1:0]  qcnt_q;

	logic        in_acc, out_acc;
	logic [3:0]  root_n;
	logic [7:0]  sym_n;
	logic [12:0] hash_x;
	logic [IdxW-1:0] hash_i;
	logic [IdxW:0]   hx_sum, st_sum;
	logic [IdxW-1:0] hx_nx, st_nx;
	logic        hit, slot_empty, exhausted, full;
	logic [3:0]  w_nx;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign out_valid = (qcnt_q != 2'd0);
	assign out_data  = q0_q;

	assign root_n = root_from_reg(reg_min_q);
	assign sym_n  = in_data.symbol & 8'((9'd1 << root_q) - 9'd1);
	assign hash_x = {1'b0, pending_q} ^ {sym_n, 5'd0};
	assign hash_i = (hash_x >= 13'(HashEntries)) ? IdxW'(hash_x - 13'(HashEntries))
		: IdxW'(hash_x);
	assign hx_sum = {1'b0, hx_q} + {1'b0, step_q};
	assign hx_nx  = (hx_sum >= NWide) ? IdxW'(hx_sum - NWide) : IdxW'(hx_sum);
	assign st_sum = {1'b0, step_q} + (IdxW + 1)'(2);
	assign st_nx  = (st_sum >= NWide) ? IdxW'(st_sum - NWide) : IdxW'(st_sum);
	assign slot_empty = (rd_q.code == 12'd0);
	assign hit = !slot_empty && rd_q.prefix == pending_q && rd_q.suffix == sym_q;
	assign exhausted = (tries_q == LastIdx);
	assign full = (next_free_q >= limit_q) && (width_q == 4'(MaxCodeBits));
	assign w_nx = width_q + 4'd1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == LastIdx) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc) begin
					if (in_data.operation == OpFinish) state_d = have_q ? ST_CLEAR : ST_IDLE;
					else if (have_q) state_d = ST_PROBE;
				end
			end
			ST_PROBE: state_d = ST_CHECK;
			ST_CHECK: begin
				if (hit) state_d = ST_IDLE;
				else if (slot_empty || exhausted) state_d = ST_MISS;
				else state_d = ST_PROBE;
			end
			ST_MISS: state_d = full ? ST_CLEAR : ST_IDLE;
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = hx_q;
		wr_data  = '0;
		case (state_q)
			ST_IDLE: in_ready = (qcnt_q == 2'd0);
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			ST_MISS: begin
				wr_en   = empty_q && (next_free_q < 13'(1 << MaxCodeBits));
				wr_data = '{code: next_free_q[11:0], prefix: pending_q, suffix: sym_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[hx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			reg_min_q   <= 4'd8;
			reg_tiff_q  <= 1'b0;
			root_q      <= 4'd8;
			tiff_q      <= 1'b0;
			pending_q   <= '0;
			have_q      <= 1'b0;
			next_free_q <= 13'd258;
			width_q     <= 4'd9;
			limit_q     <= 13'd512;
			clr_q       <= '0;
			qcnt_q      <= '0;
			q0_q        <= '0;
			q1_q        <= '0;
			sym_q       <= '0;
			hx_q        <= '0;
			step_q      <= '0;
			tries_q     <= '0;
			empty_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				if (cfg_index == RegMinCodeSize) reg_min_q <= cfg_data;
				if (cfg_index == RegTiffMode) reg_tiff_q <= cfg_data[0];
			end
			if (out_acc) begin
				q0_q   <= q1_q;
				qcnt_q <= qcnt_q - 2'd1;
			end
			case (state_q)
				ST_CLEAR: clr_q <= (clr_q == LastIdx) ? '0 : clr_q + IdxW'(1);
				ST_IDLE: begin
					if (in_acc) begin
						if (in_data.operation == OpFinish) begin
							if (have_q) begin
								q0_q <= '{out_code: pending_q, out_width: width_q, last_of_run: 1'b0};
								q1_q <= '{out_code: 12'((13'd1 << root_q) + 13'd1),
									out_width: width_q, last_of_run: 1'b1};
							end else begin
								root_q <= root_n;
								tiff_q <= reg_tiff_q;
								q0_q <= '{out_code: 12'(13'd1 << root_n), out_width: root_n + 4'd1,
									last_of_run: 1'b0};
								q1_q <= '{out_code: 12'((13'd1 << root_n) + 13'd1),
									out_width: root_n + 4'd1, last_of_run: 1'b1};
							end
							qcnt_q <= 2'd2;
							have_q <= 1'b0;
						end else if (!have_q) begin
							root_q      <= root_n;
							tiff_q      <= reg_tiff_q;
							width_q     <= root_n + 4'd1;
							limit_q     <= limit_for(root_n + 4'd1, reg_tiff_q);
							next_free_q <= (13'd1 << root_n) + 13'd2;
							q0_q <= '{out_code: 12'(13'd1 << root_n), out_width: root_n + 4'd1,
								last_of_run: 1'b1};
							qcnt_q    <= 2'd1;
							pending_q <= 12'(in_data.symbol & 8'((9'd1 << root_n) - 9'd1));
							have_q    <= 1'b1;
						end else begin
							sym_q   <= sym_n;
							hx_q    <= hash_i;
							step_q  <= IdxW'(1);
							tries_q <= '0;
						end
					end
				end
				ST_CHECK: begin
					empty_q <= slot_empty;
					if (hit) pending_q <= rd_q.code;
					else if (!slot_empty && !exhausted) begin
						hx_q    <= hx_nx;
						step_q  <= st_nx;
						tries_q <= tries_q + IdxW'(1);
					end
				end
				ST_MISS: begin
					q0_q <= '{out_code: pending_q, out_width: width_q, last_of_run: !full};
					q1_q <= '{out_code: 12'(13'd1 << root_q), out_width: width_q,
						last_of_run: 1'b1};
					qcnt_q <= full ? 2'd2 : 2'd1;
					pending_q <= {4'd0, sym_q};
					if (full) begin
						width_q     <= root_q + 4'd1;
						limit_q     <= limit_for(root_q + 4'd1, tiff_q);
						next_free_q <= (13'd1 << root_q) + 13'd2;
					end else begin
						if (next_free_q < 13'(1 << MaxCodeBits)) next_free_q <= next_free_q + 13'd1;
						if (next_free_q >= limit_q) begin
							width_q <= w_nx;
							limit_q <= limit_for(w_nx, tiff_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

/* test/lzw_hash_encoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_hash_encoder_test
// Drives symbol and finish requests into the LZW hash encoder under several
// root sizes and both width modes, including a long wide-symbol stream, and
// checks every emitted code, width and last flag against a local string-table
// model.
// ----------------------------------------------------------------------------
module lzw_hash_encoder_test;
	import lzw_pkg::*;

	localparam int IdleLimit = 60000;
	localparam int Settle    = 64;

	typedef enum int {ROW_ITEM, ROW_MIN, ROW_TIFF} row_kind_t;
	typedef struct {
		row_kind_t   kind;
		logic [0:0]  op;
		int unsigned val;
		int          n_codes;
		int          lead_code;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [3:0] cfg_data;
	logic in_valid;
	logic in_ready;
	lzw_in_t in_data;
	logic out_valid;
	logic out_ready;
	lzw_out_t out_data;

	lzw_out_t expected_codes[$];
	int errors;
	int before_n;
	bit calm;
	bit hold_req;

	int unsigned slot_code[HashEntries];
	int unsigned slot_prefix[HashEntries];
	int unsigned slot_suffix[HashEntries];
	int unsigned pend, nfree, wnow, wlim, root, tiff_on, reg_min, reg_tiff;
	bit have;

	lzw_hash_encoder u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic void wipe_strings();
		for (int i = 0; i < HashEntries; i++) slot_code[i] = 0;
	endfunction

	function automatic void restart_widths();
		wnow = root + 1;
		wlim = (1 << wnow) - tiff_on;
		nfree = (1 << root) + 2;
	endfunction

	function automatic void open_stream();
		root = reg_min < 2 ? 2 : (reg_min > 8 ? 8 : reg_min);
		tiff_on = reg_tiff;
		wipe_strings();
		restart_widths();
		pend = 0;
		have = 0;
	endfunction

	function automatic void push_code(input int unsigned code, input int unsigned w,
			input bit last);
		lzw_out_t r;
		r.out_code = code[11:0];
		r.out_width = w[3:0];
		r.last_of_run = last;
		expected_codes.push_back(r);
	endfunction

	function automatic void predict_codes(input lzw_in_t item);
		int unsigned s, hx, step, tries, d;
		bit empty, full;
		empty = 0;
		if (item.operation == OpFinish) begin
			if (have) begin
				push_code(pend, wnow, 0);
			end else begin
				open_stream();
				push_code(1 << root, wnow, 0);
			end
			push_code((1 << root) + 1, wnow, 1);
			open_stream();
			return;
		end
		if (!have) begin
			open_stream();
			push_code(1 << root, wnow, 1);
			pend = item.symbol & ((1 << root) - 1);
			have = 1;
			return;
		end
		s = item.symbol & ((1 << root) - 1);
		hx = (pend ^ (s << HashShift)) % HashEntries;
		step = 1;
		for (tries = 0; tries < HashEntries; tries++) begin
			if (slot_code[hx] == 0) begin
				empty = 1;
				break;
			end
			if (slot_prefix[hx] == pend && slot_suffix[hx] == s) begin
				pend = slot_code[hx];
				return;
			end
			hx = (hx + step) % HashEntries;
			step += 2;
		end
		d = nfree;
		full = (d >= wlim) && (wnow >= MaxCodeBits);
		push_code(pend, wnow, !full);
		if (d < (1 << MaxCodeBits)) begin
			if (empty) begin
				slot_prefix[hx] = pend;
				slot_suffix[hx] = s;
				slot_code[hx] = d;
			end
			nfree = d + 1;
		end
		if (d >= wlim) begin
			if (!full) begin
				wnow++;
				wlim = (1 << wnow) - tiff_on;
			end else begin
				push_code(1 << root, wnow, 1);
				wipe_strings();
				restart_widths();
			end
		end
		pend = s;
	endfunction

	// results
	initial begin
		int hold_left;
		lzw_out_t want;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_codes.size() == 0) begin
					report_mismatch($sformatf("unexpected code %0d", out_data.out_code));
				end else begin
					want = expected_codes.pop_front();
					if (out_data.out_code !== want.out_code)
						report_mismatch($sformatf("code %0d, want %0d",
							out_data.out_code, want.out_code));
					if (out_data.out_width !== want.out_width)
						report_mismatch($sformatf("width %0d, want %0d",
							out_data.out_width, want.out_width));
					if (out_data.last_of_run !== want.last_of_run)
						report_mismatch($sformatf("last %0b, want %0b",
							out_data.last_of_run, want.last_of_run));
				end
			end
			if (hold_req) begin
				hold_req = 0;
				hold_left = 400;
			end
			out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 6);
			if (hold_left > 0) hold_left--;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IdleLimit) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [0:0] op, input logic [7:0] sym);
		lzw_in_t item;
		item.operation = op;
		item.symbol = sym;
		while (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		before_n = expected_codes.size();
		predict_codes(item);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[3:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == RegMinCodeSize) reg_min = value & 4'hF;
		else reg_tiff = value & 1;
		@(posedge clk);
	endtask

	row_t plan[22];

	initial begin
		int len, mode;
		logic [7:0] sym;
		errors = 0;
		before_n = 0;
		calm = 1;
		hold_req = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = RegMinCodeSize;
		cfg_data = 4'd0;
		in_valid = 1'b0;
		in_data = '0;
		reg_min = 8;
		reg_tiff = 0;
		open_stream();

		plan = '{
			'{ROW_ITEM, OpFinish, 0,   2, 256},
			'{ROW_ITEM, OpSymbol, 0,   1, 256},
			'{ROW_ITEM, OpSymbol, 255, 1, 0},
			'{ROW_ITEM, OpSymbol, 0,   1, 255},
			'{ROW_ITEM, OpSymbol, 255, 0, -1},
			'{ROW_ITEM, OpSymbol, 0,   1, 258},
			'{ROW_ITEM, OpFinish, 0,   2, 0},
			'{ROW_MIN,  OpSymbol, 1,  -1, -1},
			'{ROW_TIFF, OpSymbol, 1,  -1, -1},
			'{ROW_ITEM, OpSymbol, 255, 1, 4},
			'{ROW_ITEM, OpSymbol, 2,   1, 3},
			'{ROW_ITEM, OpSymbol, 1,  -1, -1},
			'{ROW_ITEM, OpSymbol, 0,  -1, -1},
			'{ROW_ITEM, OpSymbol, 3,  -1, -1},
			'{ROW_ITEM, OpSymbol, 2,  -1, -1},
			'{ROW_ITEM, OpSymbol, 1,  -1, -1},
			'{ROW_ITEM, OpFinish, 0,   2, -1},
			'{ROW_MIN,  OpSymbol, 0,  -1, -1},
			'{ROW_TIFF, OpSymbol, 0,  -1, -1},
			'{ROW_ITEM, OpFinish, 0,   2, 4},
			'{ROW_MIN,  OpSymbol, 15, -1, -1},
			'{ROW_ITEM, OpSymbol, 128, 1, 256}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_ITEM) begin
				send_request(plan[i].op, plan[i].val[7:0]);
				if (plan[i].n_codes >= 0 &&
						expected_codes.size() - before_n != plan[i].n_codes)
					report_mismatch($sformatf("row %0d: code count", i));
				if (plan[i].lead_code >= 0 &&
						expected_codes[before_n].out_code != plan[i].lead_code)
					report_mismatch($sformatf("row %0d: first code", i));
			end else begin
				wait_drained();
				write_reg(plan[i].kind == ROW_MIN ? RegMinCodeSize : RegTiffMode,
					plan[i].val);
			end
		end
		send_request(OpFinish, 8'd0);
		wait_drained();

		// long stream of wide random symbols: the code width grows from 9 to at most 10 bits
		write_reg(RegMinCodeSize, 8);
		write_reg(RegTiffMode, $urandom_range(1));
		calm = 0;
		for (int i = 0; i < 500; i++) send_request(OpSymbol, 8'($urandom));
		send_request(OpFinish, 8'd0);
		wait_drained();

		for (int phase = 0; phase < 16; phase++) begin
			write_reg(RegMinCodeSize, phase < 2 ? phase * 15 : $urandom_range(15));
			write_reg(RegTiffMode, phase & 1);
			calm = (phase == 3);
			mode = $urandom_range(2);
			len = $urandom_range(20, 100);
			for (int i = 0; i < len; i++) begin
				if (phase == 5 && i == 10) hold_req = 1;
				if ($urandom_range(99) < 2) begin
					send_request(OpFinish, 8'($urandom));
				end else begin
					sym = mode == 0 ? 8'($urandom) : 8'($urandom_range(3));
					if (mode == 2 && $urandom_range(9) == 0) sym = 8'($urandom);
					send_request(OpSymbol, sym);
				end
			end
			send_request(OpFinish, 8'($urandom));
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (errors == 0 && expected_codes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
